[rtl/bts_pkg.sv]
package bts_pkg;

    // Default storage sizes.
    localparam int IMAGE_BYTES_DEF     = 65536;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Internal address width: covers (width*height + x) * 4 for 13-bit sizes.
    localparam int ADDR_W     = 30;
    // Palette index compare width: holds any index up to 65536.
    localparam int PAL_IDX_W  = 17;

    // Field widths.
    localparam int KIND_W     = 2;
    localparam int LOAD_ADR_W = 16;
    localparam int LOAD_VAL_W = 24;
    localparam int FRAC_W     = 16;
    localparam int PLANE_W    = 2;
    localparam int BPP_W      = 3;
    localparam int SIZE_W     = 13;
    localparam int COORD_W    = 13;
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 24;
    localparam int SV_W       = 16;

    // Stream widths.
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd2;

    localparam logic [BPP_W-1:0]  BPP_RESET    = 3'd3;
    localparam logic [BPP_W-1:0]  BPP_MONO     = 3'd0;
    localparam logic [BPP_W-1:0]  BPP_DIRECT   = 3'd3;
    localparam logic [BPP_W-1:0]  BPP_MAX      = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 13'd1;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_IMAGE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd2;

    // Plane selectors.
    localparam logic [PLANE_W-1:0] PLANE_LUMA  = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_RED   = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_GREEN = 2'd2;
    localparam logic [PLANE_W-1:0] PLANE_BLUE  = 2'd3;

    // Luma weights, summing to 256.
    localparam logic [CHAN_W-1:0] LUMA_WR = 8'd77;
    localparam logic [CHAN_W-1:0] LUMA_WG = 8'd151;
    localparam logic [CHAN_W-1:0] LUMA_WB = 8'd28;

    localparam logic [RGB_W-1:0] RGB_WHITE = 24'hFFFFFF;
    localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Sequencer states.
    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_MUL_X   = 14'b00000000000010,
        ST_MUL_Y   = 14'b00000000000100,
        ST_MUL_ROW = 14'b00000000001000,
        ST_MUL_N   = 14'b00000000010000,
        ST_CHECK   = 14'b00000000100000,
        ST_FETCH   = 14'b00000001000000,
        ST_LAST    = 14'b00000010000000,
        ST_DECODE  = 14'b00000100000000,
        ST_COLOR   = 14'b00001000000000,
        ST_LUMA_R  = 14'b00010000000000,
        ST_LUMA_G  = 14'b00100000000000,
        ST_LUMA_B  = 14'b01000000000000,
        ST_OUT     = 14'b10000000000000
    } state_t;

endpackage

[rtl/bts_ram.sv]
module bts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port with registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bitmap_texture_sampler_core.sv]
// Texture sampler over a stored bitmap. Requests on the slave stream either load one image
// byte (kind 0), load one 24-bit palette colour (kind 1) or sample a texel (kind 2); only a
// sample produces a result. A load request is written on acceptance; the block stays idle.
// A sample request occupies the block until its result is handed over: four products on the
// single shared multiplier form the pixel address and a check state tests it, and an address
// beyond the image store goes straight to a black result. Otherwise the single-port image
// memory delivers one byte per cycle (1 to 4 bytes by format), then a state for the last read
// and one to decode; palette formats add one palette read (an index beyond the palette gives
// black), and the luma plane takes three more passes through the multiplier. The finished
// result moves to an output register, so the next request is taken while it is still unread;
// the hand-over itself waits as long as an earlier result still sits unread there. The image
// and palette memories are not cleared at reset: every entry must be loaded before a sample
// reads it. Configuration must be written only while idle; the block does not enforce this.
module bitmap_texture_sampler_core #(
    parameter int IMAGE_BYTES     = bts_pkg::IMAGE_BYTES_DEF,
    parameter int PALETTE_ENTRIES = bts_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Request stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // From bit 0: load_address, load_value, x_frac, y_frac, plane, zero fill.
    input  logic [bts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // From bit 0: kind.
    input  logic [bts_pkg::KIND_W-1:0]     s_axis_tuser,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // From bit 0: sample_value, red, green, blue.
    output logic [bts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // From bit 0: range_error.
    output logic                           m_axis_tuser
);

    localparam int IMG_AW = $clog2(IMAGE_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
    localparam logic [bts_pkg::ADDR_W:0] IMG_LIMIT =
        (bts_pkg::ADDR_W + 1)'(IMAGE_BYTES);
    localparam logic [bts_pkg::PAL_IDX_W-1:0] PAL_LIMIT =
        bts_pkg::PAL_IDX_W'(PALETTE_ENTRIES);

    // Request fields.
    logic [bts_pkg::LOAD_ADR_W-1:0] in_load_address;
    logic [bts_pkg::LOAD_VAL_W-1:0] in_load_value;
    logic [bts_pkg::FRAC_W-1:0]     in_x_frac;
    logic [bts_pkg::FRAC_W-1:0]     in_y_frac;
    logic [bts_pkg::PLANE_W-1:0]    in_plane;
    logic                           in_accept;

    // Configuration registers.
    logic [bts_pkg::BPP_W-1:0]  bpp_reg;
    logic [bts_pkg::SIZE_W-1:0] width_reg;
    logic [bts_pkg::SIZE_W-1:0] height_reg;

    // Sequencer and datapath registers.
    bts_pkg::state_t             state_reg, state_next;
    logic [bts_pkg::FRAC_W-1:0]  xf_reg, xf_next;
    logic [bts_pkg::FRAC_W-1:0]  yf_reg, yf_next;
    logic [bts_pkg::PLANE_W-1:0] plane_reg, plane_next;
    logic [bts_pkg::COORD_W-1:0] px_reg, px_next;
    logic [bts_pkg::COORD_W-1:0] py_reg, py_next;
    logic [25:0]                 prod_reg, prod_next;
    logic [bts_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [2:0]                  left_reg, left_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [bts_pkg::RGB_W-1:0]   pix_reg, pix_next;
    logic [bts_pkg::RGB_W-1:0]   rgb_reg, rgb_next;
    logic                        err_reg, err_next;
    logic [bts_pkg::SV_W-1:0]    acc_reg, acc_next;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic [bts_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                          m_err_reg, m_err_next;

    // Shared multiplier.
    logic [bts_pkg::MUL_A_W-1:0] mul_a;
    logic [bts_pkg::MUL_B_W-1:0] mul_b;
    logic [bts_pkg::MUL_P_W-1:0] mul_p;

    // Derived values.
    logic                        is_mono;
    logic [2:0]                  nbytes;
    logic [13:0]                 width_plus7;
    logic [10:0]                 mono_row;
    logic [26:0]                 base_addr;
    logic [bts_pkg::ADDR_W:0]    end_addr;
    logic [bts_pkg::ADDR_W-1:0]  load_adr_ext;
    logic [bts_pkg::PAL_IDX_W-1:0] load_pal_ext;
    logic [bts_pkg::PAL_IDX_W-1:0] pix_pal_ext;
    logic [bts_pkg::CHAN_W-1:0]  red_c, green_c, blue_c, sel_chan;
    logic                        mono_bit;

    // Memory ports.
    logic                        img_we;
    logic [IMG_AW-1:0]           img_addr;
    logic [bts_pkg::CHAN_W-1:0]  img_rdata;
    logic                        pal_we;
    logic [PAL_AW-1:0]           pal_addr;
    logic [bts_pkg::RGB_W-1:0]   pal_rdata;

    // Unpack the request.
    assign in_load_address = s_axis_tdata[15:0];
    assign in_load_value   = s_axis_tdata[39:16];
    assign in_x_frac       = s_axis_tdata[55:40];
    assign in_y_frac       = s_axis_tdata[71:56];
    assign in_plane        = s_axis_tdata[73:72];

    assign s_axis_tready = (state_reg == bts_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg    <= bts_pkg::BPP_RESET;
            width_reg  <= bts_pkg::SIZE_RESET;
            height_reg <= bts_pkg::SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                bts_pkg::REG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wdata[bts_pkg::BPP_W-1:0];
                bts_pkg::REG_IMAGE_WIDTH:     width_reg  <= cfg_wdata;
                bts_pkg::REG_IMAGE_HEIGHT:    height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Format decode: codes above four behave as four.
    assign is_mono     = (bpp_reg == bts_pkg::BPP_MONO);
    assign nbytes      = is_mono ? 3'd1 :
                         (bpp_reg > bts_pkg::BPP_MAX) ? bts_pkg::BPP_MAX : bpp_reg;
    assign width_plus7 = 14'(width_reg) + 14'd7;
    assign mono_row    = width_plus7[13:3];
    assign base_addr   = 27'(prod_reg) + (is_mono ? 27'(px_reg[12:3]) : 27'(px_reg));
    assign end_addr    = {1'b0, addr_reg} + (bts_pkg::ADDR_W + 1)'(nbytes);

    assign load_adr_ext = bts_pkg::ADDR_W'(in_load_address);
    assign load_pal_ext = bts_pkg::PAL_IDX_W'(in_load_address);
    assign pix_pal_ext  = bts_pkg::PAL_IDX_W'(pix_reg[15:0]);

    assign red_c    = rgb_reg[23:16];
    assign green_c  = rgb_reg[15:8];
    assign blue_c   = rgb_reg[7:0];
    assign mono_bit = pix_reg[3'd7 - px_reg[2:0]];

    always_comb begin
        case (plane_reg)
            bts_pkg::PLANE_GREEN: sel_chan = green_c;
            bts_pkg::PLANE_BLUE:  sel_chan = blue_c;
            default:              sel_chan = red_c;
        endcase
    end

    assign mul_p = bts_pkg::MUL_P_W'(mul_a) * bts_pkg::MUL_P_W'(mul_b);

    // Memory port selection: loads write while idle, the sequencer reads otherwise.
    assign img_we   = in_accept && (s_axis_tuser == bts_pkg::KIND_IMAGE) &&
                      ({1'b0, load_adr_ext} < IMG_LIMIT);
    assign img_addr = (state_reg == bts_pkg::ST_FETCH) ? addr_reg[IMG_AW-1:0]
                                                       : load_adr_ext[IMG_AW-1:0];
    assign pal_we   = in_accept && (s_axis_tuser == bts_pkg::KIND_PALETTE) &&
                      (load_pal_ext < PAL_LIMIT);
    assign pal_addr = (state_reg == bts_pkg::ST_DECODE) ? pix_pal_ext[PAL_AW-1:0]
                                                        : load_pal_ext[PAL_AW-1:0];

    bts_ram #(
        .WIDTH (bts_pkg::CHAN_W),
        .DEPTH (IMAGE_BYTES)
    ) u_image_ram (
        .aclk  (aclk),
        .we    (img_we),
        .addr  (img_addr),
        .wdata (in_load_value[bts_pkg::CHAN_W-1:0]),
        .rdata (img_rdata)
    );

    bts_ram #(
        .WIDTH (bts_pkg::RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette_ram (
        .aclk  (aclk),
        .we    (pal_we),
        .addr  (pal_addr),
        .wdata (in_load_value),
        .rdata (pal_rdata)
    );

    // Sequencer: each state makes at most one pass through the shared multiplier or a memory.
    always_comb begin
        state_next   = state_reg;
        xf_next      = xf_reg;
        yf_next      = yf_reg;
        plane_next   = plane_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        prod_next    = prod_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        rd_pend_next = (state_reg == bts_pkg::ST_FETCH);
        pix_next     = rd_pend_reg ? {pix_reg[15:0], img_rdata} : pix_reg;
        rgb_next     = rgb_reg;
        err_next     = err_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_err_next   = m_err_reg;
        mul_a        = '0;
        mul_b        = '0;

        case (state_reg)
            bts_pkg::ST_IDLE: begin
                if (in_accept && (s_axis_tuser == bts_pkg::KIND_SAMPLE)) begin
                    xf_next    = in_x_frac;
                    yf_next    = in_y_frac;
                    plane_next = in_plane;
                    state_next = bts_pkg::ST_MUL_X;
                end
            end
            bts_pkg::ST_MUL_X: begin
                mul_a      = bts_pkg::MUL_A_W'(width_reg);
                mul_b      = xf_reg;
                px_next    = mul_p[28:16];
                err_next   = 1'b0;
                state_next = bts_pkg::ST_MUL_Y;
            end
            bts_pkg::ST_MUL_Y: begin
                mul_a      = bts_pkg::MUL_A_W'(height_reg);
                mul_b      = yf_reg;
                py_next    = mul_p[28:16];
                state_next = bts_pkg::ST_MUL_ROW;
            end
            bts_pkg::ST_MUL_ROW: begin
                // Row offset: padded bytes per row for monochrome, pixels otherwise.
                mul_a      = is_mono ? bts_pkg::MUL_A_W'(mono_row)
                                     : bts_pkg::MUL_A_W'(width_reg);
                mul_b      = bts_pkg::MUL_B_W'(py_reg);
                prod_next  = mul_p[25:0];
                state_next = bts_pkg::ST_MUL_N;
            end
            bts_pkg::ST_MUL_N: begin
                mul_a      = base_addr;
                mul_b      = bts_pkg::MUL_B_W'(nbytes);
                addr_next  = mul_p[bts_pkg::ADDR_W-1:0];
                state_next = bts_pkg::ST_CHECK;
            end
            bts_pkg::ST_CHECK: begin
                pix_next  = '0;
                left_next = nbytes;
                if (end_addr > IMG_LIMIT) begin
                    err_next   = 1'b1;
                    rgb_next   = bts_pkg::RGB_BLACK;
                    state_next = bts_pkg::ST_LUMA_R;
                end else begin
                    state_next = bts_pkg::ST_FETCH;
                end
            end
            bts_pkg::ST_FETCH: begin
                // One byte address a cycle; the registered read data shifts in behind it.
                addr_next = addr_reg + bts_pkg::ADDR_W'(1);
                left_next = left_reg - 3'd1;
                if (left_reg == 3'd1) begin
                    state_next = bts_pkg::ST_LAST;
                end
            end
            bts_pkg::ST_LAST: begin
                state_next = bts_pkg::ST_DECODE;
            end
            bts_pkg::ST_DECODE: begin
                if (is_mono) begin
                    rgb_next   = mono_bit ? bts_pkg::RGB_WHITE : bts_pkg::RGB_BLACK;
                    state_next = bts_pkg::ST_LUMA_R;
                end else if (nbytes >= bts_pkg::BPP_DIRECT) begin
                    rgb_next   = pix_reg;
                    state_next = bts_pkg::ST_LUMA_R;
                end else if (pix_pal_ext < PAL_LIMIT) begin
                    state_next = bts_pkg::ST_COLOR;
                end else begin
                    err_next   = 1'b1;
                    rgb_next   = bts_pkg::RGB_BLACK;
                    state_next = bts_pkg::ST_LUMA_R;
                end
            end
            bts_pkg::ST_COLOR: begin
                rgb_next   = pal_rdata;
                state_next = bts_pkg::ST_LUMA_R;
            end
            bts_pkg::ST_LUMA_R: begin
                if (plane_reg == bts_pkg::PLANE_LUMA) begin
                    mul_a      = bts_pkg::MUL_A_W'(red_c);
                    mul_b      = bts_pkg::MUL_B_W'(bts_pkg::LUMA_WR);
                    acc_next   = mul_p[bts_pkg::SV_W-1:0];
                    state_next = bts_pkg::ST_LUMA_G;
                end else begin
                    acc_next   = {sel_chan, 8'h00};
                    state_next = bts_pkg::ST_OUT;
                end
            end
            bts_pkg::ST_LUMA_G: begin
                mul_a      = bts_pkg::MUL_A_W'(green_c);
                mul_b      = bts_pkg::MUL_B_W'(bts_pkg::LUMA_WG);
                acc_next   = acc_reg + mul_p[bts_pkg::SV_W-1:0];
                state_next = bts_pkg::ST_LUMA_B;
            end
            bts_pkg::ST_LUMA_B: begin
                mul_a      = bts_pkg::MUL_A_W'(blue_c);
                mul_b      = bts_pkg::MUL_B_W'(bts_pkg::LUMA_WB);
                acc_next   = acc_reg + mul_p[bts_pkg::SV_W-1:0];
                state_next = bts_pkg::ST_OUT;
            end
            bts_pkg::ST_OUT: begin
                // Hand over once the output register is free.
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {blue_c, green_c, red_c, acc_reg};
                    m_err_next   = err_reg;
                    state_next   = bts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bts_pkg::ST_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        xf_reg     <= xf_next;
        yf_reg     <= yf_next;
        plane_reg  <= plane_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        prod_reg   <= prod_next;
        addr_reg   <= addr_next;
        left_reg   <= left_next;
        pix_reg    <= pix_next;
        rgb_reg    <= rgb_next;
        err_reg    <= err_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
        m_err_reg  <= m_err_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_err_reg;

`ifndef SYNTHESIS
    // A result only appears after the sequencer has passed its output state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == bts_pkg::ST_OUT))
        else $error("result raised outside the output state");

    // A range error always comes with a black pixel and a zero plane value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("range error with non-black result");

    // The byte fetch never runs with an exhausted byte count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bts_pkg::ST_FETCH) |-> (left_reg != 3'd0))
        else $error("byte fetch with no bytes left");
`endif

endmodule

[tb/tb_bitmap_texture_sampler_core.sv]
module tb_bitmap_texture_sampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IMG_BYTES      = bts_pkg::IMAGE_BYTES_DEF;
    localparam int unsigned PAL_ENTRIES    = bts_pkg::PALETTE_ENTRIES_DEF;
    localparam int unsigned RANDOM_ITEMS   = 1150;
    localparam int unsigned SETTLE_CYCLES  = 24;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;

    // Codes not named in the package.
    localparam logic [bts_pkg::KIND_W-1:0] KIND_UNUSED   = 2'd3;
    localparam logic [bts_pkg::BPP_W-1:0]  BPP_INDEX8    = 3'd1;
    localparam logic [bts_pkg::BPP_W-1:0]  BPP_INDEX16   = 3'd2;
    localparam logic [bts_pkg::BPP_W-1:0]  BPP_WIDE_CODE = 3'd7;

    typedef struct packed {
        logic [bts_pkg::SV_W-1:0]   sample_value;
        logic [bts_pkg::CHAN_W-1:0] red;
        logic [bts_pkg::CHAN_W-1:0] green;
        logic [bts_pkg::CHAN_W-1:0] blue;
        logic                       range_error;
    } texel_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [bts_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [bts_pkg::KIND_W-1:0]     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [bts_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                           m_axis_tuser;

    // Shadow copy of the block's stores and registers.
    logic [7:0]                 image_mem [IMG_BYTES];
    bit                         image_ok  [IMG_BYTES];
    logic [bts_pkg::RGB_W-1:0]  pal_mem   [PAL_ENTRIES];
    bit                         pal_ok    [PAL_ENTRIES];
    logic [bts_pkg::BPP_W-1:0]  bpp_cfg    = bts_pkg::BPP_RESET;
    logic [bts_pkg::SIZE_W-1:0] width_cfg  = bts_pkg::SIZE_RESET;
    logic [bts_pkg::SIZE_W-1:0] height_cfg = bts_pkg::SIZE_RESET;

    texel_t      texel_queue [$];
    bit          source_burst = 1'b0;
    bit          sink_burst   = 1'b0;
    int unsigned counted_items  = 0;
    int unsigned sample_count   = 0;
    int unsigned load_count     = 0;
    int unsigned config_count   = 0;
    int unsigned error_results  = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    bitmap_texture_sampler_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Scales the coordinates to a pixel and gives the byte span that it occupies.
    function automatic void pixel_span(input logic [bts_pkg::FRAC_W-1:0] xf,
                                       input logic [bts_pkg::FRAC_W-1:0] yf,
                                       output int unsigned base, output int unsigned nbytes,
                                       output logic [2:0] bit_sel);
        logic [28:0]  xs;
        logic [28:0]  ys;
        int unsigned  px;
        int unsigned  py;
        int unsigned  w;
        xs = 29'(xf) * 29'(width_cfg);
        ys = 29'(yf) * 29'(height_cfg);
        px = 32'(xs[28:16]);
        py = 32'(ys[28:16]);
        w = 32'(width_cfg);
        bit_sel = px[2:0];
        if (bpp_cfg == bts_pkg::BPP_MONO) begin
            nbytes = 1;
            base = ((w + 7) / 8) * py + px / 8;
        end else begin
            nbytes = (bpp_cfg > bts_pkg::BPP_MAX) ? 32'd4 : 32'(bpp_cfg);
            base = (w * py + px) * nbytes;
        end
    endfunction

    // Works out the texel that a sample request must return from the shadow state.
    function automatic texel_t predict_texel(input logic [bts_pkg::FRAC_W-1:0] xf,
                                             input logic [bts_pkg::FRAC_W-1:0] yf,
                                             input logic [bts_pkg::PLANE_W-1:0] plane);
        int unsigned               base;
        int unsigned               nbytes;
        logic [2:0]                bit_sel;
        logic [31:0]               word;
        logic [bts_pkg::RGB_W-1:0] rgb;
        logic                      bad;
        texel_t                    t;
        pixel_span(xf, yf, base, nbytes, bit_sel);
        bad = (base + nbytes > IMG_BYTES);
        rgb = bts_pkg::RGB_BLACK;
        word = '0;
        if (!bad) begin
            for (int i = 0; i < nbytes; i++)
                word = {word[23:0], image_mem[base + i]};
            if (bpp_cfg == bts_pkg::BPP_MONO) begin
                rgb = word[7 - bit_sel] ? bts_pkg::RGB_WHITE : bts_pkg::RGB_BLACK;
            end else if (nbytes < 3) begin
                if (word < PAL_ENTRIES)
                    rgb = pal_mem[word[7:0]];
                else
                    bad = 1'b1;
            end else begin
                rgb = word[23:0];
            end
        end
        if (bad)
            rgb = bts_pkg::RGB_BLACK;
        t.red = rgb[23:16];
        t.green = rgb[15:8];
        t.blue = rgb[7:0];
        t.range_error = bad;
        case (plane)
            bts_pkg::PLANE_RED:   t.sample_value = {t.red, 8'h00};
            bts_pkg::PLANE_GREEN: t.sample_value = {t.green, 8'h00};
            bts_pkg::PLANE_BLUE:  t.sample_value = {t.blue, 8'h00};
            default: begin
                t.sample_value = 16'(t.red) * 16'(bts_pkg::LUMA_WR)
                               + 16'(t.green) * 16'(bts_pkg::LUMA_WG)
                               + 16'(t.blue) * 16'(bts_pkg::LUMA_WB);
            end
        endcase
        return t;
    endfunction

    // Offers one request, waits for its acceptance and updates the shadow state.
    task automatic send_request(input logic [bts_pkg::KIND_W-1:0] kind,
                                input logic [15:0] adr, input logic [23:0] val,
                                input logic [bts_pkg::FRAC_W-1:0] xf,
                                input logic [bts_pkg::FRAC_W-1:0] yf,
                                input logic [bts_pkg::PLANE_W-1:0] plane);
        int unsigned gap;
        gap = source_burst ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, plane, yf, xf, val, adr};
        s_axis_tuser <= kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        case (kind)
            bts_pkg::KIND_IMAGE: begin
                image_mem[adr] = val[7:0];
                image_ok[adr] = 1'b1;
                counted_items++;
                load_count++;
            end
            bts_pkg::KIND_PALETTE: begin
                if (adr < PAL_ENTRIES) begin
                    pal_mem[adr[7:0]] = val;
                    pal_ok[adr[7:0]] = 1'b1;
                    counted_items++;
                    load_count++;
                end
            end
            bts_pkg::KIND_SAMPLE: begin
                texel_queue.push_back(predict_texel(xf, yf, plane));
                counted_items++;
                sample_count++;
            end
            default: ;
        endcase
    endtask

    task automatic load_image_byte(input logic [15:0] adr, input logic [7:0] val);
        send_request(bts_pkg::KIND_IMAGE, adr, {16'($urandom), val}, 16'($urandom),
                     16'($urandom), 2'($urandom));
    endtask

    task automatic load_palette(input logic [15:0] adr,
                                input logic [bts_pkg::RGB_W-1:0] colour);
        send_request(bts_pkg::KIND_PALETTE, adr, colour, 16'($urandom), 16'($urandom),
                     2'($urandom));
    endtask

    // Loads every byte and palette entry that a sample will read and that is still unwritten.
    task automatic load_pixel_sources(input logic [bts_pkg::FRAC_W-1:0] xf,
                                      input logic [bts_pkg::FRAC_W-1:0] yf);
        int unsigned base;
        int unsigned nbytes;
        logic [2:0]  bit_sel;
        logic [31:0] idx;
        logic [7:0]  val;
        pixel_span(xf, yf, base, nbytes, bit_sel);
        if (base + nbytes <= IMG_BYTES) begin
            for (int i = 0; i < nbytes; i++) begin
                if (!image_ok[base + i]) begin
                    val = 8'($urandom);
                    // Keep most 16-bit indexes inside the palette.
                    if (nbytes == 2 && i == 0 && $urandom_range(0, 3) != 0)
                        val = 8'h00;
                    load_image_byte(16'(base + i), val);
                end
            end
            if (bpp_cfg != bts_pkg::BPP_MONO && nbytes < 3) begin
                idx = '0;
                for (int i = 0; i < nbytes; i++)
                    idx = {idx[23:0], image_mem[base + i]};
                if (idx < PAL_ENTRIES && !pal_ok[idx[7:0]])
                    load_palette(idx[15:0], 24'($urandom));
            end
        end
    endtask

    task automatic sample_texel(input logic [bts_pkg::FRAC_W-1:0] xf,
                                input logic [bts_pkg::FRAC_W-1:0] yf,
                                input logic [bts_pkg::PLANE_W-1:0] plane);
        load_pixel_sources(xf, yf);
        send_request(bts_pkg::KIND_SAMPLE, 16'($urandom), 24'($urandom), xf, yf, plane);
    endtask

    // Lets the block run dry before the registers are touched.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (texel_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [bts_pkg::BPP_W-1:0] bpp,
                                input logic [bts_pkg::SIZE_W-1:0] w,
                                input logic [bts_pkg::SIZE_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= bts_pkg::REG_BYTES_PER_PIXEL;
        cfg_wdata <= bts_pkg::CFG_DATA_W'(bpp);
        @(posedge aclk);
        cfg_index <= bts_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= bts_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        bpp_cfg = bpp;
        width_cfg = w;
        height_cfg = h;
        config_count++;
    endtask

    // Direct RGB with the reset settings on a single-pixel image.
    task automatic test_reset_format();
        load_image_byte(16'd0, 8'hFF);
        load_image_byte(16'd1, 8'h00);
        load_image_byte(16'd2, 8'h80);
        sample_texel(16'h0000, 16'h0000, bts_pkg::PLANE_LUMA);
        sample_texel(16'hFFFF, 16'hFFFF, bts_pkg::PLANE_RED);
        sample_texel(16'h8000, 16'h0000, bts_pkg::PLANE_GREEN);
        sample_texel(16'h0000, 16'hFFFF, bts_pkg::PLANE_BLUE);
    endtask

    // Monochrome with a padded row: set bits give white, clear bits black.
    task automatic test_mono_bits();
        settle_block();
        write_config(bts_pkg::BPP_MONO, 13'd9, 13'd2);
        load_image_byte(16'd0, 8'h80);
        load_image_byte(16'd1, 8'h7F);
        load_image_byte(16'd2, 8'h01);
        load_image_byte(16'd3, 8'hFE);
        sample_texel(16'h0000, 16'h0000, bts_pkg::PLANE_LUMA);
        sample_texel(16'hFFFF, 16'h0000, bts_pkg::PLANE_RED);
        sample_texel(16'h7000, 16'h8000, bts_pkg::PLANE_LUMA);
        sample_texel(16'hFFFF, 16'hFFFF, bts_pkg::PLANE_BLUE);
    endtask

    // Two-byte palette index, in range and beyond the palette, plus an ignored load.
    task automatic test_palette_index();
        settle_block();
        write_config(BPP_INDEX16, 13'd2, 13'd1);
        load_image_byte(16'd0, 8'h00);
        load_image_byte(16'd1, 8'h05);
        load_image_byte(16'd2, 8'h01);
        load_image_byte(16'd3, 8'h00);
        load_palette(16'd5, bts_pkg::RGB_WHITE);
        load_palette(16'd255, 24'h123456);
        load_palette(16'd300, 24'hABCDEF);
        sample_texel(16'h0000, 16'h0000, bts_pkg::PLANE_LUMA);
        sample_texel(16'h8000, 16'h0000, bts_pkg::PLANE_RED);
    endtask

    // A wide format code reads four bytes; a zero size pins the pixel to the origin.
    task automatic test_wide_and_degenerate();
        settle_block();
        write_config(BPP_WIDE_CODE, 13'd0, 13'd0);
        load_image_byte(16'd3, 8'h5A);
        sample_texel(16'hFFFF, 16'hFFFF, bts_pkg::PLANE_LUMA);
        send_request(KIND_UNUSED, 16'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                     2'($urandom));
        sample_texel(16'h0000, 16'hFFFF, bts_pkg::PLANE_GREEN);
    endtask

    // A 4096-square four-byte image overflows the store: far samples are black with an error.
    task automatic test_out_of_range();
        settle_block();
        write_config(bts_pkg::BPP_MAX, 13'd4096, 13'd4096);
        sample_texel(16'h0000, 16'hFFFF, bts_pkg::PLANE_LUMA);
        sample_texel(16'hFFFF, 16'hFFFF, bts_pkg::PLANE_BLUE);
        sample_texel(16'h0000, 16'h0000, bts_pkg::PLANE_RED);
    endtask

    function automatic logic [bts_pkg::SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 13'd0;
            1:       return 13'd4096;
            2:       return 13'd8191;
            default: return 13'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [bts_pkg::FRAC_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Random phases, each with its own settings and mostly samples.
    task automatic test_random_mix();
        int unsigned target;
        int unsigned phase;
        int unsigned phase_items;
        int unsigned r;
        target = counted_items + RANDOM_ITEMS;
        phase = 0;
        while (counted_items < target) begin
            settle_block();
            case (phase)
                0:       write_config(bts_pkg::BPP_MONO, 13'd4096, 13'd4096);
                1:       write_config(BPP_WIDE_CODE, 13'd8191, 13'd8191);
                2:       write_config(BPP_INDEX8, 13'd16, 13'd16);
                default: write_config(3'($urandom_range(0, 7)), pick_size(), pick_size());
            endcase
            source_burst = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(60, 140);
            repeat (phase_items) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    sample_texel(pick_coord(), pick_coord(), 2'($urandom));
                end else if (r < 82) begin
                    send_request(bts_pkg::KIND_IMAGE, 16'($urandom), 24'($urandom),
                                 16'($urandom), 16'($urandom), 2'($urandom));
                end else if (r < 92) begin
                    load_palette($urandom_range(0, 1) ? 16'($urandom_range(0, PAL_ENTRIES - 1))
                                                      : 16'($urandom), 24'($urandom));
                end else begin
                    send_request(KIND_UNUSED, 16'($urandom), 24'($urandom), 16'($urandom),
                                 16'($urandom), 2'($urandom));
                end
            end
            phase++;
        end
        source_burst = 1'b0;
        sink_burst = 1'b0;
    endtask

    // Result side: a random stall before each result is taken, outside burst phases.
    initial begin : result_sink
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    function automatic void note_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    // Each accepted result is compared with the oldest expected texel.
    always @(posedge aclk) begin : result_check
        texel_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (texel_queue.size() == 0) begin
                note_mismatch("result with nothing expected", 0, m_axis_tdata[31:0]);
            end else begin
                want = texel_queue.pop_front();
                if (m_axis_tdata[15:0] !== want.sample_value)
                    note_mismatch("sample_value", 32'(want.sample_value),
                                  32'(m_axis_tdata[15:0]));
                if (m_axis_tdata[23:16] !== want.red)
                    note_mismatch("red", 32'(want.red), 32'(m_axis_tdata[23:16]));
                if (m_axis_tdata[31:24] !== want.green)
                    note_mismatch("green", 32'(want.green), 32'(m_axis_tdata[31:24]));
                if (m_axis_tdata[39:32] !== want.blue)
                    note_mismatch("blue", 32'(want.blue), 32'(m_axis_tdata[39:32]));
                if (m_axis_tuser !== want.range_error)
                    note_mismatch("range_error", 32'(want.range_error), 32'(m_axis_tuser));
                if (want.range_error)
                    error_results++;
            end
        end
        // Watchdog on cycles in which neither side moves a request or a result.
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", texel_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_format();
        test_mono_bits();
        test_palette_index();
        test_wide_and_degenerate();
        test_out_of_range();
        test_random_mix();
        settle_block();
        $display("Checked %0d samples (%0d flagged out of range) after %0d loads,",
                 sample_count, error_results, load_count);
        $display("over %0d register settings; %0d mismatches.", config_count, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bitmap_texture_sampler_core.sv
tb/tb_bitmap_texture_sampler_core.sv
